// File: sv/assert_macros.svh
// Assertion macros shared by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a property holds at every rising edge of clk outside reset.
`define SDQR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdqr assertion failed");

// Checks that a condition never holds at a rising edge of clk outside reset.
`define SDQR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sdqr forbidden condition seen");

`else

`define SDQR_ASSERT(lbl, prop)
`define SDQR_NEVER(lbl, cond)

`endif

`endif

// File: sv/sdqr_pkg.sv
// Package with the types and constants of the signed divider.
package sdqr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] ONE_W = DATA_WIDTH'(1);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } op_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic signed [DATA_WIDTH-1:0] remainder;
        logic                         divide_by_zero;
    } res_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

endpackage

// File: sv/sdqr_unit.sv
// Restoring shift and subtract unit that produces one quotient bit per step.
module sdqr_unit (
    input  logic                                   clk,
    input  sdqr_pkg::unit_ctrl_t                   ctrl,
    input  logic [sdqr_pkg::DATA_WIDTH-1:0]        dividend_mag,
    input  logic [sdqr_pkg::DATA_WIDTH-1:0]        divisor_mag,
    output logic [sdqr_pkg::DATA_WIDTH-1:0]        quo,
    output logic [sdqr_pkg::DATA_WIDTH-1:0]        rem
);

    logic [sdqr_pkg::DATA_WIDTH-1:0] quo_reg;
    logic [sdqr_pkg::DATA_WIDTH-1:0] quo_next;
    logic [sdqr_pkg::DATA_WIDTH-1:0] rem_reg;
    logic [sdqr_pkg::DATA_WIDTH-1:0] rem_next;
    logic [sdqr_pkg::DATA_WIDTH-1:0] den_reg;
    logic [sdqr_pkg::DATA_WIDTH-1:0] den_next;
    logic [sdqr_pkg::DATA_WIDTH+1:0] diff;

    // The partial remainder gains the next dividend bit, then the divisor is tried.
    assign diff = {1'b0, rem_reg, quo_reg[sdqr_pkg::DATA_WIDTH-1]} - {2'b00, den_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (ctrl.load)
        begin
            quo_next = dividend_mag;
            rem_next = '0;
            den_next = divisor_mag;
        end
        else if (ctrl.step)
        begin
            if (diff[sdqr_pkg::DATA_WIDTH+1])
            begin
                rem_next = {rem_reg[sdqr_pkg::DATA_WIDTH-2:0],
                            quo_reg[sdqr_pkg::DATA_WIDTH-1]};
                quo_next = {quo_reg[sdqr_pkg::DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[sdqr_pkg::DATA_WIDTH-1:0];
                quo_next = {quo_reg[sdqr_pkg::DATA_WIDTH-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

// File: sv/signed_divider_quotient_remainder.sv
// Top level of the signed divider: sequencer, sign handling and result register.
//
// The op channel carries one word holding a signed dividend and divisor; the
// res channel returns one word with the quotient (truncated toward zero), the
// remainder (sign of the dividend) and a divide-by-zero flag. Both channels
// use valid and ready.
// A word is accepted only while the divider is idle. The magnitudes are
// loaded into a single restoring subtract unit at acceptance, which then
// produces one quotient bit per cycle, DATA_WIDTH bits in all; the fix state
// then fixes the signs and writes the result register, which raises result
// valid. A new word can be accepted only once the divider is back in idle,
// so the divider works on one word at a time.
// The result register lets a new word start while the previous result waits.
// If the receiver still holds off when the next result is ready, the divider
// waits in its fix state until the result register frees up.
// A zero divisor gives zero quotient and remainder with the flag set; the
// most negative value divided by minus one wraps to the most negative value.
// Reset clears result valid and returns the divider to idle; the result word itself is not reset.
`include "assert_macros.svh"

module signed_divider_quotient_remainder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  sdqr_pkg::op_word_t    op_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output sdqr_pkg::res_word_t   res_word
);

    localparam int W = sdqr_pkg::DATA_WIDTH;

    sdqr_pkg::state_t            state_reg;
    sdqr_pkg::state_t            state_next;
    logic [sdqr_pkg::CNT_W-1:0]  cnt_reg;
    logic [sdqr_pkg::CNT_W-1:0]  cnt_next;
    logic                        neg_q_reg;
    logic                        neg_q_next;
    logic                        neg_r_reg;
    logic                        neg_r_next;
    logic                        zero_reg;
    logic                        zero_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    sdqr_pkg::res_word_t         res_word_reg;
    sdqr_pkg::res_word_t         res_word_next;
    sdqr_pkg::unit_ctrl_t        ctrl;
    logic                        accept;
    logic                        emit;
    logic [W-1:0]                a_bits;
    logic [W-1:0]                b_bits;
    logic [W-1:0]                a_mag;
    logic [W-1:0]                b_mag;
    logic [W-1:0]                quo;
    logic [W-1:0]                rem;
    logic [W-1:0]                q_fix;
    logic [W-1:0]                r_fix;

    assign op_ready = (state_reg == sdqr_pkg::ST_IDLE);
    assign accept   = op_valid && op_ready;
    assign emit     = (state_reg == sdqr_pkg::ST_FIX) && (!res_valid_reg || res_ready);

    assign a_bits = op_word.dividend;
    assign b_bits = op_word.divisor;
    assign a_mag  = a_bits[W-1] ? (~a_bits + sdqr_pkg::ONE_W) : a_bits;
    assign b_mag  = b_bits[W-1] ? (~b_bits + sdqr_pkg::ONE_W) : b_bits;

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == sdqr_pkg::ST_DIV);

    sdqr_unit u_unit (
        .clk          (clk),
        .ctrl         (ctrl),
        .dividend_mag (a_mag),
        .divisor_mag  (b_mag),
        .quo          (quo),
        .rem          (rem)
    );

    assign q_fix = neg_q_reg ? (~quo + sdqr_pkg::ONE_W) : quo;
    assign r_fix = neg_r_reg ? (~rem + sdqr_pkg::ONE_W) : rem;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        zero_next      = zero_reg;
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            sdqr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_q_next = a_bits[W-1] ^ b_bits[W-1];
                    neg_r_next = a_bits[W-1];
                    zero_next  = (b_bits == '0);
                    cnt_next   = sdqr_pkg::CNT_MAX;
                    state_next = sdqr_pkg::ST_DIV;
                end
            end
            sdqr_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = sdqr_pkg::ST_FIX;
                end
            end
            sdqr_pkg::ST_FIX:
            begin
                if (emit)
                begin
                    res_word_next.quotient       = zero_reg ? '0 : q_fix;
                    res_word_next.remainder      = zero_reg ? '0 : r_fix;
                    res_word_next.divide_by_zero = zero_reg;
                    res_valid_next               = 1'b1;
                    state_next                   = sdqr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdqr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdqr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_q_reg    <= neg_q_next;
        neg_r_reg    <= neg_r_next;
        zero_reg     <= zero_next;
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    `SDQR_ASSERT(a_accept_starts_div,
        (op_valid && op_ready) |=>
        (state_reg == sdqr_pkg::ST_DIV && cnt_reg == sdqr_pkg::CNT_MAX))
    `SDQR_ASSERT(a_result_from_fix,
        $rose(res_valid) |-> $past(state_reg == sdqr_pkg::ST_FIX))
    `SDQR_ASSERT(a_zero_flag_clears_fields,
        (res_valid && res_word.divide_by_zero) |->
        (res_word.quotient == '0 && res_word.remainder == '0))
    `SDQR_NEVER(a_load_during_step, ctrl.load && ctrl.step)

endmodule
